/* hdl/irfp_pkg.sv */
package irfp_pkg;

    // Magic word that opens every request frame
    localparam logic [31:0] FRAME_MAGIC = 32'h2310_7231;

    // Parser phases; the unused code 7 behaves as drain
    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_OP    = 3'd1,
        PH_LEN1  = 3'd2,
        PH_PAY1  = 3'd3,
        PH_LEN2  = 3'd4,
        PH_PAY2  = 3'd5,
        PH_DRAIN = 3'd6
    } t_phase;

    // Result event codes
    typedef enum logic [2:0] {
        EV_IMG1      = 3'd0,
        EV_IMG2      = 3'd1,
        EV_BAD_MAGIC = 3'd2,
        EV_BAD_OP    = 3'd3,
        EV_ZERO      = 3'd4,
        EV_LARGE     = 3'd5,
        EV_TRUNC     = 3'd6
    } t_event;

    // One result item as handed from the parser core to the output register
    typedef struct packed {
        logic        valid;
        t_event      ev;
        logic [7:0]  data;
        logic        op;
        logic [31:0] len;
        logic        last;
    } t_result;

endpackage

/* hdl/image_request_frame_parser_top.sv */
// Channel   Dir  Payload                                        Handshake
// s_*       in   tdata: data_byte; tlast: stream_end            tvalid/tready
// m_*       out  tdata: payload_byte, request_op, image_length  tvalid/tready
//                tuser: event_res; tlast: last_byte
// cfg_*     in   wdata: image size limit, zero for none          we, no wait
//
// One byte per clock sustained while the output is not stalled; each transfer
// passes the input register, then parse logic into the output register.
// Synchronous active-low reset rearms the parser and clears the size limit.
// A stalled output holds its result; the input register still takes a
// transfer when it is itself empty or the output will be drained in the same cycle.
module image_request_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // stream_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [7:0] payload_byte, [8] request_op,
                                     // [40:9] image_length, [47:41] zero
    output logic [2:0]  o_m_tuser,   // [2:0] event_res
    output logic        o_m_tlast,   // last_byte
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic [31:0]       r_max_size;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_end;
    logic              r_out_valid;
    irfp_pkg::t_result r_out;
    irfp_pkg::t_result w_res;
    logic              w_out_free;
    logic              w_step;

    // Output register can take a new result when empty or being drained
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    // Hold the size limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= 32'd0;
        end else if (i_cfg_we) begin
            r_max_size <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
    end

    irfp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (r_in_byte),
        .i_end      (r_in_end),
        .i_max_size (r_max_size),
        .o_res      (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.len, r_out.op, r_out.data};
    assign o_m_tuser  = r_out.ev;
    assign o_m_tlast  = r_out.last;

endmodule

/* hdl/irfp_core.sv */
module irfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    input  logic [31:0]       i_max_size,
    output irfp_pkg::t_result o_res
);

    irfp_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_hc, n_hc;
    logic [31:0]      r_gather, n_gather;
    logic [31:0]      r_left, n_left;
    logic [31:0]      r_hlen, n_hlen;
    logic             r_hop, n_hop;

    logic [31:0] w_word;
    logic        w_full;
    logic [1:0]  w_hc_inc;
    logic [31:0] w_left_dec;
    logic        w_left_last;
    logic        w_len_zero;
    logic        w_len_large;

    // Shared datapath: gather shift, byte count, payload countdown, length checks
    assign w_word      = {i_byte, r_gather[31:8]};
    assign w_full      = (r_hc == 2'd3);
    assign w_hc_inc    = r_hc + 2'd1;
    assign w_left_dec  = r_left - 32'd1;
    assign w_left_last = (w_left_dec == 32'd0);
    assign w_len_zero  = (w_word == 32'd0);
    assign w_len_large = (i_max_size != 32'd0) && (w_word > i_max_size);

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_hc     = r_hc;
        n_gather = r_gather;
        n_left   = r_left;
        n_hlen   = r_hlen;
        n_hop    = r_hop;
        if (i_end) begin
            // rearm on stream end
            n_phase  = irfp_pkg::PH_MAGIC;
            n_hc     = 2'd0;
            n_gather = 32'd0;
            n_left   = 32'd0;
            n_hlen   = 32'd0;
            n_hop    = 1'b0;
        end else begin
            unique case (r_phase)
                irfp_pkg::PH_MAGIC: begin
                    n_hc     = w_hc_inc;
                    n_gather = w_word;
                    if (w_full) begin
                        n_gather = 32'd0;
                        if (w_word != irfp_pkg::FRAME_MAGIC) begin
                            n_phase = irfp_pkg::PH_DRAIN;
                        end else begin
                            n_phase = irfp_pkg::PH_OP;
                            n_hop   = 1'b0;
                            n_hlen  = 32'd0;
                        end
                    end
                end
                irfp_pkg::PH_OP: begin
                    if (i_byte[7:1] != 7'd0) begin
                        n_phase = irfp_pkg::PH_DRAIN;
                    end else begin
                        n_hop   = i_byte[0];
                        n_phase = irfp_pkg::PH_LEN1;
                    end
                end
                irfp_pkg::PH_LEN1, irfp_pkg::PH_LEN2: begin
                    n_hc     = w_hc_inc;
                    n_gather = w_word;
                    if (w_full) begin
                        n_gather = 32'd0;
                        if (w_len_zero || w_len_large) begin
                            n_phase = irfp_pkg::PH_DRAIN;
                        end else begin
                            n_hlen  = w_word;
                            n_left  = w_word;
                            n_phase = (r_phase == irfp_pkg::PH_LEN1) ?
                                      irfp_pkg::PH_PAY1 : irfp_pkg::PH_PAY2;
                        end
                    end
                end
                irfp_pkg::PH_PAY1, irfp_pkg::PH_PAY2: begin
                    n_left = w_left_dec;
                    if (w_left_last) begin
                        n_hc     = 2'd0;
                        n_gather = 32'd0;
                        if (r_phase == irfp_pkg::PH_PAY1 && r_hop) begin
                            n_phase = irfp_pkg::PH_LEN2;
                        end else begin
                            n_phase = irfp_pkg::PH_MAGIC;
                        end
                    end
                end
                default: begin
                    // drain: ignore bytes
                end
            endcase
        end
    end

    // Result for the item in the input register
    always_comb begin
        o_res       = '0;
        o_res.ev    = irfp_pkg::EV_TRUNC;
        o_res.op    = r_hop;
        o_res.len   = r_hlen;
        if (i_end) begin
            o_res.valid = (r_phase != irfp_pkg::PH_DRAIN) &&
                          (r_phase != irfp_pkg::t_phase'(3'd7));
        end else begin
            unique case (r_phase)
                irfp_pkg::PH_MAGIC: begin
                    o_res.valid = w_full && (w_word != irfp_pkg::FRAME_MAGIC);
                    o_res.ev    = irfp_pkg::EV_BAD_MAGIC;
                end
                irfp_pkg::PH_OP: begin
                    o_res.valid = (i_byte[7:1] != 7'd0);
                    o_res.ev    = irfp_pkg::EV_BAD_OP;
                end
                irfp_pkg::PH_LEN1, irfp_pkg::PH_LEN2: begin
                    o_res.valid = w_full && (w_len_zero || w_len_large);
                    o_res.ev    = w_len_zero ? irfp_pkg::EV_ZERO : irfp_pkg::EV_LARGE;
                    o_res.len   = w_word;
                end
                irfp_pkg::PH_PAY1, irfp_pkg::PH_PAY2: begin
                    o_res.valid = 1'b1;
                    o_res.ev    = (r_phase == irfp_pkg::PH_PAY1) ?
                                  irfp_pkg::EV_IMG1 : irfp_pkg::EV_IMG2;
                    o_res.data  = i_byte;
                    o_res.last  = w_left_last;
                end
                default: begin
                    o_res.valid = 1'b0;
                end
            endcase
        end
    end

    // State registers advance once per consumed transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= irfp_pkg::PH_MAGIC;
            r_hc     <= 2'd0;
            r_gather <= 32'd0;
            r_left   <= 32'd0;
            r_hlen   <= 32'd0;
            r_hop    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_hc     <= n_hc;
            r_gather <= n_gather;
            r_left   <= n_left;
            r_hlen   <= n_hlen;
            r_hop    <= n_hop;
        end
    end

    // A stream end always rearms the parser
    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_end) |=> (r_phase == irfp_pkg::PH_MAGIC && r_hc == 2'd0))
        else $error("parser not rearmed after stream end");

    // Header byte count only runs while a header word is gathered
    a_hc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hc != 2'd0) |-> (r_phase == irfp_pkg::PH_MAGIC ||
                            r_phase == irfp_pkg::PH_LEN1 ||
                            r_phase == irfp_pkg::PH_LEN2))
        else $error("header count left over outside a header phase");

    // Payload phases always have bytes still due
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == irfp_pkg::PH_PAY1 || r_phase == irfp_pkg::PH_PAY2)
            |-> (r_left != 32'd0 && r_hlen != 32'd0))
        else $error("payload phase with no bytes due");

    // A payload byte never goes out with a zero length
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.valid &&
         (o_res.ev == irfp_pkg::EV_IMG1 || o_res.ev == irfp_pkg::EV_IMG2))
            |-> (o_res.len != 32'd0))
        else $error("payload byte with zero image length");

endmodule
